FILE: hdl/rwt_pkg.sv
// Shared definitions for the retransmit window tracker.
// Holds operation and status codes, the command word type and default sizes.
// No dependencies.
package rwt_pkg;

	localparam int unsigned WINDOW_DEF  = 3;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned SEQ_W       = 32;
	localparam int unsigned AGE_W       = 8;
	localparam logic [AGE_W-1:0] TIMEOUT_RST = 8'd3;
	localparam logic [AGE_W-1:0] AGE_MAX     = 8'hFF;

	// Operation codes, equal to the input kind codes; kind seven is a no-op.
	localparam logic [2:0] OP_SETUP    = 3'd0;
	localparam logic [2:0] OP_SEND     = 3'd1;
	localparam logic [2:0] OP_ACK      = 3'd2;
	localparam logic [2:0] OP_TICK     = 3'd3;
	localparam logic [2:0] OP_SCAN     = 3'd4;
	localparam logic [2:0] OP_RESEND   = 3'd5;
	localparam logic [2:0] OP_TEARDOWN = 3'd6;
	localparam logic [2:0] OP_NOP      = 3'd7;

	// Result status codes.
	localparam logic [2:0] ST_SETUP    = 3'd0;
	localparam logic [2:0] ST_SENT     = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_ACKED    = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;
	localparam logic [2:0] ST_RESENT   = 3'd5;
	localparam logic [2:0] ST_TEARDOWN = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	typedef struct packed {
		logic [2:0]       op;
		logic [SEQ_W-1:0] ack_seq;
	} cmd_t;

endpackage

FILE: hdl/rwt_front.sv
// Front end of the retransmit window tracker: accepts input words and
// classifies them into command words. Depends on rwt_pkg.
module rwt_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 kind,
	input  logic [rwt_pkg::SEQ_W-1:0]  ack_seq,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output rwt_pkg::cmd_t              cmd
);
	import rwt_pkg::*;

	logic cmd_vld_q;
	cmd_t cmd_q;
	cmd_t cmd_dec;

	// Only an acknowledgement carries a sequence number further on.
	always_comb begin
		cmd_dec.op      = kind;
		cmd_dec.ack_seq = (kind == OP_ACK) ? ack_seq : '0;
	end

	assign in_ready  = !cmd_vld_q || cmd_ready;
	assign cmd_valid = cmd_vld_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			cmd_vld_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_dec;
		end
	end

endmodule

FILE: hdl/rwt_cmd_queue.sv
// Short command queue between the front and back ends.
// Depends on rwt_pkg for the command word type and the queue depth.
module rwt_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rwt_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rwt_pkg::cmd_t pop_cmd
);
	import rwt_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: hdl/rwt_back.sv
// Back end of the retransmit window tracker: slot store, sequencer that walks
// the slots one per cycle, timeout register and output register.
// Depends on rwt_pkg.
module rwt_back #(
	parameter int unsigned WINDOW = rwt_pkg::WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rwt_pkg::AGE_W-1:0]  cfg_wdata,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  rwt_pkg::cmd_t              cmd,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [rwt_pkg::SEQ_W-1:0]  seq_out,
	output logic                       last,
	output logic                       window_open,
	output logic                       resend_pending
);
	import rwt_pkg::*;

	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned OCC_W = $clog2(WINDOW + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        op_q;
	logic [SEQ_W-1:0]  ack_q;
	logic [IDX_W-1:0]  idx_q;
	logic              flag_q;
	logic              found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [SEQ_W-1:0]  best_seq_q;
	logic [2:0]        res_status_q;
	logic [SEQ_W-1:0]  res_seq_q;
	logic              res_last_q;

	logic [WINDOW-1:0] valid_q;
	logic [WINDOW-1:0] marked_q;
	logic [SEQ_W-1:0]  seq_q [WINDOW];
	logic [AGE_W-1:0]  age_q [WINDOW];
	logic [OCC_W-1:0]  occ_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [AGE_W-1:0]  limit_q;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [SEQ_W-1:0]  seq_out_q;
	logic              last_q;
	logic              window_open_q;
	logic              rp_q;

	logic              cur_valid;
	logic              cur_marked;
	logic [SEQ_W-1:0]  cur_seq;
	logic              scan_end;
	logic              emit_ok;
	logic              alloc_en;
	logic              resend_fin;
	logic [WINDOW-1:0] best_onehot;
	logic [IDX_W-1:0]  idx_inc;

	assign cur_valid   = valid_q[idx_q];
	assign cur_marked  = marked_q[idx_q];
	assign cur_seq     = seq_q[idx_q];
	assign scan_end    = (idx_q == IDX_LAST);
	assign idx_inc     = IDX_W'(idx_q + 1'b1);
	assign emit_ok     = !out_valid_q || out_ready;
	assign alloc_en    = (state_q == S_FIN) && (op_q == OP_SEND) && !flag_q;
	assign resend_fin  = (state_q == S_FIN) && (op_q == OP_RESEND);
	assign best_onehot = WINDOW'(1) << best_idx_q;
	assign cmd_ready   = (state_q == S_IDLE);

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign seq_out        = seq_out_q;
	assign last           = last_q;
	assign window_open    = window_open_q;
	assign resend_pending = rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_NOP;
			idx_q        <= '0;
			flag_q       <= 1'b0;
			found_q      <= 1'b0;
			free_idx_q   <= '0;
			best_idx_q   <= '0;
			best_seq_q   <= '0;
			res_status_q <= ST_DONE;
			res_seq_q    <= '0;
			res_last_q   <= 1'b1;
			valid_q      <= '0;
			marked_q     <= '0;
			occ_q        <= '0;
			next_seq_q   <= '0;
			limit_q      <= TIMEOUT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (state_q == S_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.op;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q      <= '0;
					flag_q     <= 1'b0;
					found_q    <= 1'b0;
					res_seq_q  <= '0;
					res_last_q <= 1'b1;
					state_q    <= S_EMIT;
					case (op_q)
						OP_SETUP: begin
							next_seq_q   <= SEQ_W'(1);
							res_status_q <= ST_SETUP;
						end
						OP_SEND: begin
							if (occ_q == OCC_W'(WINDOW)) begin
								res_status_q <= ST_FULL;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_ACK: begin
							state_q <= S_SCAN;
						end
						OP_SCAN: begin
							for (int i = 0; i < WINDOW; i++) begin
								if (valid_q[i] && age_q[i] > limit_q) begin
									marked_q[i] <= 1'b1;
								end
							end
							res_status_q <= ST_DONE;
						end
						OP_RESEND: begin
							if (marked_q == '0) begin
								res_status_q <= ST_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end
						OP_TEARDOWN: begin
							res_status_q <= ST_TEARDOWN;
							res_seq_q    <= next_seq_q;
						end
						default: begin
							res_status_q <= ST_DONE;
						end
					endcase
				end
				S_SCAN: begin
					idx_q <= idx_inc;
					if (scan_end) begin
						state_q <= S_FIN;
					end
					case (op_q)
						OP_SEND: begin
							if (cur_valid && cur_seq == next_seq_q) begin
								flag_q <= 1'b1;
							end
							if (!cur_valid && !found_q) begin
								found_q    <= 1'b1;
								free_idx_q <= idx_q;
							end
						end
						OP_ACK: begin
							if (cur_valid && cur_seq == ack_q) begin
								valid_q[idx_q]  <= 1'b0;
								marked_q[idx_q] <= 1'b0;
								occ_q           <= OCC_W'(occ_q - 1'b1);
								flag_q          <= 1'b1;
							end
						end
						default: begin
							if (cur_marked && (!found_q || cur_seq < best_seq_q)) begin
								found_q    <= 1'b1;
								best_idx_q <= idx_q;
								best_seq_q <= cur_seq;
							end
						end
					endcase
				end
				S_FIN: begin
					state_q <= S_EMIT;
					case (op_q)
						OP_SEND: begin
							if (!flag_q) begin
								valid_q[free_idx_q]  <= 1'b1;
								marked_q[free_idx_q] <= 1'b0;
								occ_q                <= OCC_W'(occ_q + 1'b1);
							end
							res_status_q <= ST_SENT;
							res_seq_q    <= next_seq_q;
							next_seq_q   <= next_seq_q + 1'b1;
						end
						OP_ACK: begin
							res_status_q <= flag_q ? ST_ACKED : ST_IGNORED;
							res_seq_q    <= flag_q ? ack_q : '0;
						end
						default: begin
							marked_q[best_idx_q] <= 1'b0;
							res_status_q         <= ST_RESENT;
							res_seq_q            <= best_seq_q;
							res_last_q           <= ((marked_q & ~best_onehot) == '0);
						end
					endcase
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (op_q == OP_RESEND && !res_last_q) begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Slot payload and result fields carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			ack_q <= cmd.ack_seq;
		end
		for (int i = 0; i < WINDOW; i++) begin
			if (state_q == S_EXEC && op_q == OP_TICK && valid_q[i] && age_q[i] != AGE_MAX) begin
				age_q[i] <= AGE_W'(age_q[i] + 1'b1);
			end
		end
		if (alloc_en) begin
			seq_q[free_idx_q] <= next_seq_q;
			age_q[free_idx_q] <= '0;
		end
		if (resend_fin) begin
			age_q[best_idx_q] <= '0;
		end
		if (state_q == S_EMIT && emit_ok) begin
			status_q      <= res_status_q;
			seq_out_q     <= res_seq_q;
			last_q        <= res_last_q;
			window_open_q <= (occ_q < OCC_W'(WINDOW));
			rp_q          <= (op_q == OP_RESEND) ? 1'b0 : (marked_q != '0);
		end
	end

	// The occupancy counter follows the valid bits.
	a_occ_matches: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == OCC_W'($countones(valid_q)))
		else $error("occupancy count disagrees with slot valid bits");

	// A resend mark only ever sits on an outstanding slot.
	a_mark_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(marked_q & ~valid_q) == '0)
		else $error("resend mark on a free slot");

	// A slot is only filled while the window has room.
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_en |-> (occ_q < OCC_W'(WINDOW)) && !valid_q[free_idx_q])
		else $error("slot allocated into a full window or occupied slot");

	// A sent word leaves the sequence counter one further on.
	a_send_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && op_q == OP_SEND) |=> next_seq_q == $past(next_seq_q) + 1'b1)
		else $error("sequence counter did not advance on send");

endmodule

FILE: hdl/retransmit_window_tracker.sv
// Retransmit window tracker: sender side of a selective-repeat window.
// Setup, tick, scan, teardown, no-op, full-window send and unmarked resend words give their
// result without walking the slots; other sends and acks walk every slot, one slot a cycle,
// and a resend walks them once per number resent. The back end takes one word at a time,
// and output stalls hold it up.
// Reset (arst_n, asynchronous) frees all slots, clears marks, zeroes the counter, timeout 3.
module retransmit_window_tracker #(
	parameter int unsigned WINDOW = rwt_pkg::WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rwt_pkg::AGE_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 kind,
	input  logic [rwt_pkg::SEQ_W-1:0]  ack_seq,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [rwt_pkg::SEQ_W-1:0]  seq_out,
	output logic                       last,
	output logic                       window_open,
	output logic                       resend_pending
);
	import rwt_pkg::*;

	// The front end registers each accepted word and tags it with its
	// operation; only an acknowledgement keeps its sequence number.
	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;

	// The queue lets the front end keep taking words while the back end is
	// busy walking the slots or waiting for the output to drain.
	logic bk_valid;
	logic bk_ready;
	cmd_t bk_cmd;

	rwt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.ack_seq   (ack_seq),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	rwt_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_cmd   (fr_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_cmd    (bk_cmd)
	);

	// The back end holds the slots and the sequence counter. It handles one
	// word at a time: searches over the slots (duplicate check, ack match,
	// oldest-number choice for resend) walk one slot per cycle, and each
	// result passes through an output register, so that a stalled consumer
	// holds up the front end only once the queue has filled.
	rwt_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd_valid      (bk_valid),
		.cmd_ready      (bk_ready),
		.cmd            (bk_cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.seq_out        (seq_out),
		.last           (last),
		.window_open    (window_open),
		.resend_pending (resend_pending)
	);

endmodule

FILE: sim/rwt_window_checker.sv
// Checker for the retransmit window tracker: watches both word channels and the
// timeout register port, predicts every result and compares it field by field.
// Depends on rwt_pkg for the operation and status codes and the field widths.
module rwt_window_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rwt_pkg::AGE_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [2:0]                kind,
	input  logic [rwt_pkg::SEQ_W-1:0] ack_seq,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [2:0]                status,
	input  logic [rwt_pkg::SEQ_W-1:0] seq_out,
	input  logic                      last,
	input  logic                      window_open,
	input  logic                      resend_pending,
	output int                        fail_count,
	output int                        owed_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import rwt_pkg::*;

	localparam int SLOTS = WINDOW_DEF;

	typedef struct packed {
		logic [2:0]       status;
		logic [SEQ_W-1:0] seq;
		logic             last;
		logic             window_open;
		logic             resend_pending;
	} window_result_t;

	// Shadow of the window and the timeout register.
	logic             slot_busy   [SLOTS];
	logic [SEQ_W-1:0] slot_number [SLOTS];
	logic [AGE_W-1:0] slot_ticks  [SLOTS];
	logic             slot_flag   [SLOTS];
	logic [SEQ_W-1:0] next_number;
	logic [AGE_W-1:0] timeout_copy;

	window_result_t owed_results[$];

	task automatic flag_mismatch(input string msg);
		fail_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Applies one event word to the shadow window and queues the results it owes.
	task automatic advance_window(input logic [2:0] op, input logic [SEQ_W-1:0] ack);
		logic [2:0]       st [SLOTS];
		logic [SEQ_W-1:0] sq [SLOTS];
		int               n;
		int               used;
		int               best;
		logic             dup;
		logic             placed;
		logic             hit;
		logic             room;
		logic             flagged;
		window_result_t   r;
		n = 0;
		case (op)
			OP_SETUP: begin
				st[0] = ST_SETUP;
				sq[0] = '0;
				n = 1;
				next_number = SEQ_W'(1);
			end
			OP_SEND: begin
				used = 0;
				for (int i = 0; i < SLOTS; i++)
					if (slot_busy[i])
						used++;
				if (used >= SLOTS) begin
					st[0] = ST_FULL;
					sq[0] = '0;
				end else begin
					dup = 1'b0;
					for (int i = 0; i < SLOTS; i++)
						if (slot_busy[i] && slot_number[i] == next_number)
							dup = 1'b1;
					placed = dup;
					for (int i = 0; i < SLOTS; i++) begin
						if (!placed && !slot_busy[i]) begin
							slot_busy[i]   = 1'b1;
							slot_number[i] = next_number;
							slot_ticks[i]  = '0;
							slot_flag[i]   = 1'b0;
							placed         = 1'b1;
						end
					end
					st[0] = ST_SENT;
					sq[0] = next_number;
					next_number = next_number + 1'b1;
				end
				n = 1;
			end
			OP_ACK: begin
				hit = 1'b0;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_busy[i] && slot_number[i] == ack) begin
						slot_busy[i] = 1'b0;
						slot_flag[i] = 1'b0;
						hit = 1'b1;
					end
				end
				st[0] = hit ? ST_ACKED : ST_IGNORED;
				sq[0] = hit ? ack : '0;
				n = 1;
			end
			OP_TICK: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_busy[i] && slot_ticks[i] != AGE_MAX)
						slot_ticks[i] = slot_ticks[i] + 1'b1;
				st[0] = ST_DONE;
				sq[0] = '0;
				n = 1;
			end
			OP_SCAN: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_busy[i] && slot_ticks[i] > timeout_copy)
						slot_flag[i] = 1'b1;
				st[0] = ST_DONE;
				sq[0] = '0;
				n = 1;
			end
			OP_RESEND: begin
				// Marked slots go out lowest number first, one result each.
				for (int k = 0; k < SLOTS; k++) begin
					best = -1;
					for (int i = 0; i < SLOTS; i++)
						if (slot_busy[i] && slot_flag[i] &&
						    (best < 0 || slot_number[i] < slot_number[best]))
							best = i;
					if (best >= 0) begin
						slot_flag[best]  = 1'b0;
						slot_ticks[best] = '0;
						st[n] = ST_RESENT;
						sq[n] = slot_number[best];
						n++;
					end
				end
				if (n == 0) begin
					st[0] = ST_DONE;
					sq[0] = '0;
					n = 1;
				end
			end
			OP_TEARDOWN: begin
				st[0] = ST_TEARDOWN;
				sq[0] = next_number;
				n = 1;
			end
			default: begin
				st[0] = ST_DONE;
				sq[0] = '0;
				n = 1;
			end
		endcase
		room = 1'b0;
		flagged = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_busy[i])
				room = 1'b1;
			if (slot_busy[i] && slot_flag[i])
				flagged = 1'b1;
		end
		for (int k = 0; k < n; k++) begin
			r.status         = st[k];
			r.seq            = sq[k];
			r.last           = (k == n - 1);
			r.window_open    = room;
			r.resend_pending = flagged;
			owed_results.push_back(r);
		end
	endtask

	task automatic check_result();
		window_result_t want;
		if (owed_results.size() == 0) begin
			flag_mismatch($sformatf("unexpected result status %0d seq %0d", status, seq_out));
		end else begin
			want = owed_results.pop_front();
			if (status !== want.status)
				flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
			if (seq_out !== want.seq)
				flag_mismatch($sformatf("seq_out got %0d want %0d", seq_out, want.seq));
			if (last !== want.last)
				flag_mismatch($sformatf("last got %b want %b", last, want.last));
			if (window_open !== want.window_open)
				flag_mismatch($sformatf("window_open got %b want %b",
					window_open, want.window_open));
			if (resend_pending !== want.resend_pending)
				flag_mismatch($sformatf("resend_pending got %b want %b",
					resend_pending, want.resend_pending));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_busy[i]   = 1'b0;
				slot_number[i] = '0;
				slot_ticks[i]  = '0;
				slot_flag[i]   = 1'b0;
			end
			next_number  = '0;
			timeout_copy = TIMEOUT_RST;
			owed_results.delete();
			owed_count   = 0;
		end else begin
			if (cfg_we)
				timeout_copy = cfg_wdata;
			if (in_valid && in_ready)
				advance_window(kind, ack_seq);
			if (out_valid && out_ready)
				check_result();
			owed_count = owed_results.size();
		end
	end

endmodule

FILE: sim/retransmit_window_tracker_tb.sv
// Top of the retransmit window tracker testbench: clock, reset, stimulus and verdict.
// Depends on rwt_pkg, the retransmit_window_tracker RTL and rwt_window_checker.
module retransmit_window_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rwt_pkg::*;

	// Longest quiet stretch tolerated before the run is declared hung. It leaves a wide
	// margin over the slowest word (a resend of a full window) and over the receiver's
	// longest deliberate hold-off.
	localparam int HANG_LIMIT  = 4000;
	// Cycles allowed after the last result before the register is touched or the
	// run ends: roughly the latency of a full-window resend.
	localparam int SETTLE_WAIT = 3 * (WINDOW_DEF + 2) + 8;
	localparam int HOLD_CYCLES = 60;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [AGE_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic [2:0]       kind;
	logic [SEQ_W-1:0] ack_seq;
	logic             out_valid;
	logic             out_ready;
	logic [2:0]       status;
	logic [SEQ_W-1:0] seq_out;
	logic             last;
	logic             window_open;
	logic             resend_pending;

	int fail_count;
	int owed_count;

	// Set by the stimulus to ask the receiver for one long hold-off.
	logic hold_request;
	// Words left in the sender's current burst before it takes a gap.
	int   burst_left;
	// Recently sent sequence numbers, so that most acks name a real slot.
	logic [SEQ_W-1:0] sent_log[$];

	retransmit_window_tracker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.ack_seq        (ack_seq),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.seq_out        (seq_out),
		.last           (last),
		.window_open    (window_open),
		.resend_pending (resend_pending)
	);

	rwt_window_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.ack_seq        (ack_seq),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.seq_out        (seq_out),
		.last           (last),
		.window_open    (window_open),
		.resend_pending (resend_pending),
		.fail_count     (fail_count),
		.owed_count     (owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Keep a short history of the numbers the block reports as sent. This is only
	// used to steer the stimulus towards acks that hit an outstanding slot.
	always @(posedge clk) begin
		if (out_valid && out_ready && status == ST_SENT) begin
			sent_log.push_back(seq_out);
			if (sent_log.size() > 8)
				void'(sent_log.pop_front());
		end
	end

	// Receiver: alternates runs of ready and stalled cycles of random length, with
	// the odd long run of ready so that some stretches see no back-pressure at all.
	// When the stimulus asks for it, ready is held low once for a long, fixed
	// stretch counted here, so that the block fills up and has to stall its input.
	initial begin : receiver
		logic ready_phase;
		logic hold_done;
		int   run_left;
		ready_phase = 1'b0;
		hold_done   = 1'b0;
		run_left    = 0;
		out_ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					ready_phase = !ready_phase;
					if (ready_phase)
						run_left = ($urandom_range(0, 5) == 0) ? 50 : $urandom_range(1, 10);
					else
						run_left = $urandom_range(1, 5);
				end
				out_ready <= ready_phase;
				run_left--;
			end
		end
	end

	// Watchdog: ends the run if no word moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no word moved for %0d cycles", HANG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// Offers one word and returns once it has been accepted. The sender works in
	// bursts; at the end of each burst it drops valid for a random gap, so valid is
	// never lowered and raised in the same time step.
	task automatic put_word(input logic [2:0] op, input logic [SEQ_W-1:0] number);
		if (burst_left <= 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end else begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		ack_seq  <= number;
		burst_left--;
		do @(posedge clk); while (!in_ready);
	endtask

	// Picks a random event word. Sends and acks of outstanding numbers dominate so
	// that the window keeps filling and draining; the rest ages, scans and resends,
	// with the occasional setup, teardown, stray ack and no-op thrown in.
	task automatic offer_random_word();
		int               pick;
		logic [SEQ_W-1:0] noise;
		pick  = $urandom_range(0, 99);
		noise = $urandom;
		if (pick < 30)
			put_word(OP_SEND, noise);
		else if (pick < 55 && sent_log.size() > 0)
			put_word(OP_ACK, sent_log[$urandom_range(0, sent_log.size() - 1)]);
		else if (pick < 60)
			put_word(OP_ACK, noise);
		else if (pick < 75)
			put_word(OP_TICK, noise);
		else if (pick < 83)
			put_word(OP_SCAN, noise);
		else if (pick < 90)
			put_word(OP_RESEND, noise);
		else if (pick < 93)
			put_word(OP_SETUP, noise);
		else if (pick < 96)
			put_word(OP_TEARDOWN, noise);
		else
			put_word(OP_NOP, noise);
	endtask

	// Stops offering words and waits until every predicted result has come back,
	// then lets the block settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (owed_count != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [AGE_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		kind         = OP_NOP;
		ack_seq      = '0;
		hold_request = 1'b0;
		burst_left   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part with the reset timeout of 3. Teardown straight after reset
		// reports zero; then the window is filled, overflowed and partly freed.
		write_timeout(TIMEOUT_RST);
		put_word(OP_TEARDOWN, 32'h5A5A_A5A5);
		put_word(OP_SETUP, 32'hFFFF_FFFF);
		put_word(OP_SEND, 32'h0000_0000);
		put_word(OP_SEND, 32'h1234_5678);
		put_word(OP_SEND, 32'hDEAD_BEEF);
		put_word(OP_SEND, 32'h0);           // window full
		put_word(OP_TEARDOWN, 32'h0);
		put_word(OP_ACK, 32'd2);            // frees the middle slot
		put_word(OP_ACK, 32'hFFFF_FFFF);    // unknown number, ignored
		put_word(OP_ACK, 32'd0);            // never sent since setup, ignored
		// Number 4 lands in the middle slot, so slot order is 1, 4, 3 and the
		// resend has to sort them.
		put_word(OP_SEND, 32'h8000_0000);
		repeat (4) put_word(OP_TICK, 32'h0);
		put_word(OP_SCAN, 32'h0);
		put_word(OP_RESEND, 32'h0);
		put_word(OP_RESEND, 32'h0);         // nothing left marked
		put_word(OP_NOP, 32'h7FFF_FFFF);
		put_word(OP_ACK, 32'd1);
		put_word(OP_ACK, 32'd4);
		// A setup keeps number 3 outstanding, so the first two sends below fill the
		// window and the third, which would duplicate number 3, is refused as full.
		put_word(OP_SETUP, 32'h0);
		put_word(OP_SEND, 32'h0);
		put_word(OP_SEND, 32'h0);
		put_word(OP_SEND, 32'h0);
		put_word(OP_TICK, 32'h0);
		put_word(OP_SCAN, 32'h0);
		drain_results();

		// Timeout of zero: any tick followed by a scan marks. Midway the receiver
		// holds off for a long stretch while words keep coming.
		write_timeout(8'd0);
		for (int i = 0; i < 50; i++) begin
			if (i == 20)
				hold_request = 1'b1;
			offer_random_word();
		end
		drain_results();

		// Largest timeout: nothing can ever be marked.
		write_timeout(8'd255);
		for (int i = 0; i < 50; i++)
			offer_random_word();
		drain_results();

		// A small random timeout, so that marks come and go often.
		write_timeout(AGE_W'($urandom_range(1, 8)));
		for (int i = 0; i < 50; i++)
			offer_random_word();
		drain_results();

		// Timeout of one, with a pause midway until all results are back.
		write_timeout(8'd1);
		for (int i = 0; i < 50; i++) begin
			if (i == 25)
				drain_results();
			offer_random_word();
		end
		drain_results();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
